[design/okh_pkg.sv]
// ----------------------------------------------------------------------------
// okh_pkg - shared types and constants for the one-at-a-time key hash
// Widths, mix shifts, queue sizing, status structs and the byte-mix function.
// ----------------------------------------------------------------------------
package okh_pkg;

  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 17;
  localparam int IDX_W       = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd256;
  localparam logic [SIZE_W-1:0] SIZE_CAP   = 17'd65536;

  localparam int MIX_ADD_SH  = 10;
  localparam int MIX_XOR_SH  = 6;
  localparam int FIN_ADD_SH_A = 3;
  localparam int FIN_XOR_SH  = 11;
  localparam int FIN_ADD_SH_B = 15;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [HASH_W-1:0] hash_t;

  // Queue status seen by the front, the back and the top level
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Back-end status
  typedef struct packed {
    logic busy;
    logic dividing;
  } back_stat_t;

  // Fold one key byte into the running hash
  function automatic hash_t mix_byte(input hash_t hv, input logic [BYTE_W-1:0] b);
    hash_t h;
    h = hv + {{(HASH_W-BYTE_W){1'b0}}, b};
    h = h + (h << MIX_ADD_SH);
    h = h ^ (h >> MIX_XOR_SH);
    return h;
  endfunction

endpackage

[design/okh_queue.sv]
// ----------------------------------------------------------------------------
// okh_queue - small hash queue between front and back
// Holds raw key hashes so the front keeps taking bytes while the back divides.
// ----------------------------------------------------------------------------
module okh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  okh_pkg::hash_t     wr_data,
  input  logic               rd_en,
  output okh_pkg::hash_t     rd_data,
  output okh_pkg::q_stat_t   stat
);

  okh_pkg::hash_t                    mem_r [okh_pkg::QUEUE_DEPTH];
  logic [okh_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [okh_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [okh_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                              do_wr, do_rd;

  assign stat.full  = (count_r == okh_pkg::QCNT_W'(okh_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign rd_data    = mem_r[rd_ptr_r];

  assign do_wr = wr_en && !stat.full;
  assign do_rd = rd_en && !stat.empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == okh_pkg::QPTR_W'(okh_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == okh_pkg::QPTR_W'(okh_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/okh_front.sv]
// ----------------------------------------------------------------------------
// okh_front - byte intake and running hash
// Mixes one key byte per transfer; on the final byte pushes the raw hash.
// ----------------------------------------------------------------------------
module okh_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [okh_pkg::BYTE_W-1:0]   in_tdata,
  input  logic                         in_tlast,
  input  okh_pkg::q_stat_t             q_stat,
  output logic                         push,
  output okh_pkg::hash_t               push_data
);

  okh_pkg::hash_t hash_r, hash_nxt;
  okh_pkg::hash_t mixed;
  logic           take;

  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;
  assign mixed     = okh_pkg::mix_byte(hash_r, in_tdata);
  assign push      = take && in_tlast;
  assign push_data = mixed;

  // Update the running hash; clear it after the final byte
  always_comb begin
    hash_nxt = hash_r;
    if (take) begin
      hash_nxt = in_tlast ? '0 : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

[design/okh_back.sv]
// ----------------------------------------------------------------------------
// okh_back - finishing mix and bucket reduction
// Runs the three finishing steps, then a bit-serial remainder by table size.
// ----------------------------------------------------------------------------
module okh_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [okh_pkg::SIZE_W-1:0]   table_size,
  input  okh_pkg::q_stat_t             q_stat,
  input  okh_pkg::hash_t               q_data,
  output logic                         pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [okh_pkg::IDX_W-1:0]    out_tdata,
  output okh_pkg::back_stat_t          stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int STEP_W = $clog2(okh_pkg::HASH_W);
  localparam logic [STEP_W-1:0] FIN_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(okh_pkg::HASH_W - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  okh_pkg::hash_t                work_r, work_nxt;
  logic [okh_pkg::IDX_W-1:0]     rem_r, rem_nxt;
  logic [okh_pkg::SIZE_W-1:0]    div_r, div_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [okh_pkg::IDX_W-1:0]     out_data_r, out_data_nxt;
  logic [okh_pkg::SIZE_W-1:0]    trial;
  logic [okh_pkg::SIZE_W-1:0]    size_eff;
  logic                          out_free;

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.dividing  = (state_r == ST_DIV);
  assign pop            = (state_r == ST_IDLE) && !q_stat.empty;
  assign out_free       = !out_valid_r || out_tready;

  // Clamp the bucket count to the index range
  assign size_eff = (table_size > okh_pkg::SIZE_CAP) ? okh_pkg::SIZE_CAP : table_size;

  // One remainder bit per cycle
  assign trial = {rem_r, work_r[okh_pkg::HASH_W-1]};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          work_nxt  = q_data;
          div_nxt   = size_eff;
          step_nxt  = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        unique case (step_r)
          STEP_W'(0): work_nxt = work_r + (work_r << okh_pkg::FIN_ADD_SH_A);
          STEP_W'(1): work_nxt = work_r ^ (work_r >> okh_pkg::FIN_XOR_SH);
          default:    work_nxt = work_r + (work_r << okh_pkg::FIN_ADD_SH_B);
        endcase
        if (step_r == FIN_LAST) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV: begin
        work_nxt = work_r << 1;
        rem_nxt  = (trial >= div_r) ? okh_pkg::IDX_W'(trial - div_r)
                                    : okh_pkg::IDX_W'(trial);
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        // Hand the index to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (div_r == '0) ? '0 : rem_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[design/one_at_a_time_key_hash.sv]
// ----------------------------------------------------------------------------
// one_at_a_time_key_hash - key byte stream to hash bucket index
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  in_tdata = key_byte[7:0], in_tlast = last
//   out_     out  out_tvalid/out_tready out_tdata = bucket_index[15:0]
//   cfg_     in   cfg_valid/cfg_ready  cfg_data = table_size[16:0]
//
// Key bytes are taken one per cycle while the queue has room; the running hash is updated in that cycle.
// Each finished key passes through the back end in order: taking it from the queue,
// three finishing-mix steps, 64 remainder steps and the hand-off to the output.
// A two-entry queue of raw hashes lets the front keep taking bytes meanwhile;
// in_tready drops only when that queue is full. Reset (rst_n, synchronous)
// clears the hash, the queue and the output; table_size returns to 256.
// ----------------------------------------------------------------------------
module one_at_a_time_key_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [okh_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] key_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [okh_pkg::IDX_W-1:0]     out_tdata,  // [15:0] bucket_index
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [okh_pkg::SIZE_W-1:0]    cfg_data
);

  logic [okh_pkg::SIZE_W-1:0] table_size_r, table_size_nxt;
  okh_pkg::q_stat_t           q_stat;
  okh_pkg::back_stat_t        b_stat;
  okh_pkg::hash_t             push_data, q_data;
  logic                       push, pop;

  // Configuration register, always ready
  assign cfg_ready      = 1'b1;
  assign table_size_nxt = (cfg_valid && cfg_ready) ? cfg_data : table_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= okh_pkg::SIZE_RESET;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  okh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  okh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .rd_en   (pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  okh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (table_size_r),
    .q_stat     (q_stat),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (b_stat)
  );

  // Reset leaves no result pending and the intake open
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result or stall left after reset");

  // Queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= okh_pkg::QCNT_W'(okh_pkg::QUEUE_DEPTH))
    else $error("queue overfilled");

  // A finished back-end job always lands in the output register
  a_job_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(b_stat.busy) && $past(rst_n) |-> out_tvalid)
    else $error("back end finished without a result");

  // The queue is popped only while the back end is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> b_stat.busy && !b_stat.dividing)
    else $error("pop did not start a finishing pass");

endmodule
